// ----- src/kmd_pkg.sv -----
// shared types, constants and field layout for the key matrix debounce block
package kmd_pkg;

    localparam int ROWS      = 8;
    localparam int COLS      = 8;
    localparam int KEY_COUNT = ROWS * COLS;
    localparam int IDX_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    localparam int ROW_W  = 3;
    localparam int COL_W  = 3;
    localparam int TIME_W = 32;
    localparam int KIND_W = 2;

    // input word layout, lowest bit up
    localparam int IN_ROW_LSB    = 0;
    localparam int IN_COL_LSB    = IN_ROW_LSB + ROW_W;
    localparam int IN_ACTIVE_LSB = IN_COL_LSB + COL_W;
    localparam int IN_NOW_LSB    = IN_ACTIVE_LSB + 1;
    localparam int IN_BITS       = IN_NOW_LSB + TIME_W;
    localparam int IN_DATA_W     = ((IN_BITS + 7) / 8) * 8;

    // output word layout, lowest bit up
    localparam int OUT_ROW_LSB = 0;
    localparam int OUT_COL_LSB = OUT_ROW_LSB + ROW_W;
    localparam int OUT_BITS    = OUT_COL_LSB + COL_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TIME = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME     = 8'd1;
    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd5000;
    localparam logic [TIME_W-1:0] HOLD_RESET     = 32'd500000;

    typedef enum logic [1:0] {
        PH_RELEASED  = 2'd0,
        PH_TRIGGERED = 2'd1,
        PH_PRESSED   = 2'd2,
        PH_HELD      = 2'd3
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_HELD     = 2'd2,
        EV_RELEASED = 2'd3
    } ev_kind_t;

    typedef struct packed {
        phase_t              phase;
        logic [TIME_W-1:0]   change_time;
    } key_entry_t;

    localparam int ENTRY_W = $bits(key_entry_t);

    typedef struct packed {
        phase_t   next_phase;
        ev_kind_t ev_kind;
        logic     change;
    } step_t;

endpackage

// ----- src/key_matrix_debounce_hold_fsm_top.sv -----
// top level of the key matrix debounce and hold detector
// Takes one key scan sample per word and returns one event word per sample, in order.
// A new sample is accepted every cycle while the output is not stalled; each sample goes
// through the input register, lined up with the per-key state memory read, and then the
// phase update into the output register. The per-key phase and change time live in a
// 64-entry memory that is read when a sample is accepted and written back, if its phase
// changes, when its result is registered; a bypass covers a sample of the same key right
// behind. After reset all keys read as released with change time zero through per-entry
// valid bits, so there is no clearing pass. Registers are written through the cfg port at
// any time the block is idle; cfg_ready is always high.
module key_matrix_debounce_hold_fsm_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // cfg write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kmd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [kmd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // sample input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: key_row[2:0], key_col[5:3], key_active[6], now_us[38:7], zero pad
    input  logic [kmd_pkg::IN_DATA_W-1:0]    s_tdata,
    // event output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: event_row[2:0], event_col[5:3], zero pad
    output logic [kmd_pkg::OUT_DATA_W-1:0]   m_tdata,
    // m_tuser: event_kind[1:0]
    output logic [kmd_pkg::KIND_W-1:0]       m_tuser
);
    logic [kmd_pkg::TIME_W-1:0] debounce_time_reg;
    logic [kmd_pkg::TIME_W-1:0] hold_time_reg;

    logic [kmd_pkg::ROW_W-1:0]  in_row;
    logic [kmd_pkg::COL_W-1:0]  in_col;
    logic                       in_active;
    logic [kmd_pkg::TIME_W-1:0] in_now;
    logic                       in_range;
    logic [kmd_pkg::IDX_W-1:0]  in_idx;
    logic                       s_accept;

    logic                       b_valid_reg;
    logic [kmd_pkg::ROW_W-1:0]  b_row_reg;
    logic [kmd_pkg::COL_W-1:0]  b_col_reg;
    logic                       b_active_reg;
    logic [kmd_pkg::TIME_W-1:0] b_now_reg;
    logic                       b_in_range_reg;
    logic [kmd_pkg::IDX_W-1:0]  b_idx_reg;
    logic                       b_advance;

    kmd_pkg::key_entry_t        cur_entry;
    kmd_pkg::key_entry_t        wr_entry;
    kmd_pkg::step_t             step;
    logic                       wr_en;

    logic                       m_valid_reg;
    logic [kmd_pkg::ROW_W-1:0]  m_row_reg;
    logic [kmd_pkg::COL_W-1:0]  m_col_reg;
    kmd_pkg::ev_kind_t          m_kind_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg <= kmd_pkg::DEBOUNCE_RESET;
            hold_time_reg     <= kmd_pkg::HOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            priority case (cfg_index)
                kmd_pkg::REG_DEBOUNCE_TIME: debounce_time_reg <= cfg_data[kmd_pkg::TIME_W-1:0];
                kmd_pkg::REG_HOLD_TIME:     hold_time_reg     <= cfg_data[kmd_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // input word unpack and key index
    assign in_row    = s_tdata[kmd_pkg::IN_ROW_LSB +: kmd_pkg::ROW_W];
    assign in_col    = s_tdata[kmd_pkg::IN_COL_LSB +: kmd_pkg::COL_W];
    assign in_active = s_tdata[kmd_pkg::IN_ACTIVE_LSB];
    assign in_now    = s_tdata[kmd_pkg::IN_NOW_LSB +: kmd_pkg::TIME_W];
    assign in_range  = (int'(in_row) < kmd_pkg::ROWS) && (int'(in_col) < kmd_pkg::COLS);
    assign in_idx    = kmd_pkg::IDX_W'(int'(in_row) * kmd_pkg::COLS + int'(in_col));

    assign b_advance = !m_valid_reg || m_tready;
    assign s_tready  = !b_valid_reg || b_advance;
    assign s_accept  = s_tvalid && s_tready;

    // input register, lined up with the state memory read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (s_accept) begin
            b_valid_reg <= 1'b1;
        end else if (b_advance) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            b_row_reg      <= in_row;
            b_col_reg      <= in_col;
            b_active_reg   <= in_active;
            b_now_reg      <= in_now;
            b_in_range_reg <= in_range;
            b_idx_reg      <= in_idx;
        end
    end

    kmd_key_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_idx   (in_idx),
        .wr_en    (wr_en),
        .wr_idx   (b_idx_reg),
        .wr_entry (wr_entry),
        .rd_entry (cur_entry)
    );

    kmd_phase_logic u_phase (
        .entry         (cur_entry),
        .in_range      (b_in_range_reg),
        .key_active    (b_active_reg),
        .now_us        (b_now_reg),
        .debounce_time (debounce_time_reg),
        .hold_time     (hold_time_reg),
        .step          (step)
    );

    assign wr_en                = b_valid_reg && b_advance && step.change;
    assign wr_entry.phase       = step.next_phase;
    assign wr_entry.change_time = b_now_reg;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_advance) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_advance && b_valid_reg) begin
            m_row_reg  <= b_row_reg;
            m_col_reg  <= b_col_reg;
            m_kind_reg <= step.ev_kind;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {{(kmd_pkg::OUT_DATA_W - kmd_pkg::OUT_BITS){1'b0}}, m_col_reg, m_row_reg};

    // a key outside the matrix never reports an event
    a_no_event_out_of_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ((int'(m_row_reg) >= kmd_pkg::ROWS) || (int'(m_col_reg) >= kmd_pkg::COLS)))
        |-> (m_kind_reg == kmd_pkg::EV_NONE))
        else $error("event reported for a key outside the matrix");

    // every reported event comes with a state write-back
    a_event_writes_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_advance && (step.ev_kind != kmd_pkg::EV_NONE)) |-> wr_en)
        else $error("event without state update");

    // state is written only for an in-range sample leaving the input register
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (b_valid_reg && b_in_range_reg && b_advance))
        else $error("state write without a moving in-range sample");

    // a stalled sample keeps its key and timestamp
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_advance) |=> (b_valid_reg && $stable(b_idx_reg) && $stable(b_now_reg)))
        else $error("stalled sample changed");

endmodule

// ----- src/kmd_ram.sv -----
// generic single write port ram with registered read
module kmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/kmd_key_store.sv -----
// per-key phase and change time store: ram, valid bits and write bypass
module kmd_key_store (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic [kmd_pkg::IDX_W-1:0]  rd_idx,
    input  logic                       wr_en,
    input  logic [kmd_pkg::IDX_W-1:0]  wr_idx,
    input  kmd_pkg::key_entry_t        wr_entry,
    output kmd_pkg::key_entry_t        rd_entry
);
    logic [kmd_pkg::KEY_COUNT-1:0] valid_reg;
    logic                          rd_valid_reg;
    logic [kmd_pkg::ENTRY_W-1:0]   ram_rdata;

    // write that lands on the same edge as the read, forwarded over stale ram data
    logic                          fwd_hit_reg;
    kmd_pkg::key_entry_t           fwd_entry_reg;

    kmd_ram #(
        .WIDTH (kmd_pkg::ENTRY_W),
        .DEPTH (kmd_pkg::KEY_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg  <= wr_en && (wr_idx == rd_idx);
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_entry_reg <= wr_entry;
        end
    end

    always_comb begin
        priority if (fwd_hit_reg) begin
            rd_entry = fwd_entry_reg;
        end else if (rd_valid_reg) begin
            rd_entry = kmd_pkg::key_entry_t'(ram_rdata);
        end else begin
            rd_entry.phase       = kmd_pkg::PH_RELEASED;
            rd_entry.change_time = '0;
        end
    end

endmodule

// ----- src/kmd_phase_logic.sv -----
// per-key phase machine: debounce and hold checks, next phase and event
module kmd_phase_logic (
    input  kmd_pkg::key_entry_t           entry,
    input  logic                          in_range,
    input  logic                          key_active,
    input  logic [kmd_pkg::TIME_W-1:0]    now_us,
    input  logic [kmd_pkg::TIME_W-1:0]    debounce_time,
    input  logic [kmd_pkg::TIME_W-1:0]    hold_time,
    output kmd_pkg::step_t                step
);
    logic [kmd_pkg::TIME_W-1:0] elapsed;
    logic                       act;
    logic                       hold_ok;
    kmd_pkg::phase_t            next_phase;
    kmd_pkg::ev_kind_t          ev_kind;

    // modular subtraction handles timestamp wrap
    assign elapsed = now_us - entry.change_time;
    assign act     = in_range && (elapsed >= debounce_time);
    assign hold_ok = elapsed > hold_time;

    // next phase
    always_comb begin
        next_phase = entry.phase;
        if (act) begin
            unique case (entry.phase)
                kmd_pkg::PH_RELEASED: begin
                    if (key_active) next_phase = kmd_pkg::PH_TRIGGERED;
                end
                kmd_pkg::PH_TRIGGERED: begin
                    next_phase = key_active ? kmd_pkg::PH_PRESSED : kmd_pkg::PH_RELEASED;
                end
                kmd_pkg::PH_PRESSED: begin
                    if (!key_active) begin
                        next_phase = kmd_pkg::PH_RELEASED;
                    end else if (hold_ok) begin
                        next_phase = kmd_pkg::PH_HELD;
                    end
                end
                kmd_pkg::PH_HELD: begin
                    if (!key_active) next_phase = kmd_pkg::PH_RELEASED;
                end
                default: next_phase = entry.phase;
            endcase
        end
    end

    // event
    always_comb begin
        ev_kind = kmd_pkg::EV_NONE;
        if (act) begin
            unique case (entry.phase)
                kmd_pkg::PH_RELEASED: ev_kind = kmd_pkg::EV_NONE;
                kmd_pkg::PH_TRIGGERED: begin
                    if (key_active) ev_kind = kmd_pkg::EV_PRESSED;
                end
                kmd_pkg::PH_PRESSED: begin
                    if (!key_active) begin
                        ev_kind = kmd_pkg::EV_RELEASED;
                    end else if (hold_ok) begin
                        ev_kind = kmd_pkg::EV_HELD;
                    end
                end
                kmd_pkg::PH_HELD: begin
                    if (!key_active) ev_kind = kmd_pkg::EV_RELEASED;
                end
                default: ev_kind = kmd_pkg::EV_NONE;
            endcase
        end
    end

    assign step.next_phase = next_phase;
    assign step.ev_kind    = ev_kind;
    assign step.change     = (next_phase != entry.phase);

endmodule

// ----- tb/tb_key_matrix_debounce_hold_fsm_top.sv -----
// self-checking testbench for the key matrix debounce and hold detector
module tb_key_matrix_debounce_hold_fsm_top;

    localparam int QUIET_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 50;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 300;

    typedef struct packed {
        kmd_pkg::ev_kind_t          kind;
        logic [kmd_pkg::ROW_W-1:0]  row;
        logic [kmd_pkg::COL_W-1:0]  col;
    } key_event_t;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [kmd_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [kmd_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [kmd_pkg::IN_DATA_W-1:0]       s_tdata   = '0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [kmd_pkg::OUT_DATA_W-1:0]      m_tdata;
    logic [kmd_pkg::KIND_W-1:0]          m_tuser;

    // predicted per-key state and registers
    kmd_pkg::phase_t              phase_of_key  [kmd_pkg::KEY_COUNT];
    logic [kmd_pkg::TIME_W-1:0]   changed_at_us [kmd_pkg::KEY_COUNT];
    logic [kmd_pkg::TIME_W-1:0]   debounce_us;
    logic [kmd_pkg::TIME_W-1:0]   hold_us;
    key_event_t                   pending_events [$];

    int                           sender_idle_pct    = 0;
    int                           receiver_stall_pct = 0;
    int                           mismatches         = 0;
    int                           samples_sent       = 0;
    int                           reg_writes         = 0;
    int                           quiet_cycles       = 0;
    int                           kinds_seen [4]     = '{default: 0};
    logic [kmd_pkg::TIME_W-1:0]   scan_us;

    key_matrix_debounce_hold_fsm_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    function automatic key_event_t next_key_event(input logic [kmd_pkg::ROW_W-1:0] row,
                                                  input logic [kmd_pkg::COL_W-1:0] col,
                                                  input logic active,
                                                  input logic [kmd_pkg::TIME_W-1:0] now);
        key_event_t                  ev;
        int                          idx;
        logic [kmd_pkg::TIME_W-1:0]  elapsed;
        kmd_pkg::phase_t             ph;
        kmd_pkg::phase_t             nxt;
        ev.kind = kmd_pkg::EV_NONE;
        ev.row  = row;
        ev.col  = col;
        if (int'(row) < kmd_pkg::ROWS && int'(col) < kmd_pkg::COLS) begin
            idx     = int'(row) * kmd_pkg::COLS + int'(col);
            elapsed = now - changed_at_us[idx];
            ph      = phase_of_key[idx];
            nxt     = ph;
            if (elapsed >= debounce_us) begin
                if (active) begin
                    case (ph)
                        kmd_pkg::PH_RELEASED: nxt = kmd_pkg::PH_TRIGGERED;
                        kmd_pkg::PH_TRIGGERED: begin
                            nxt     = kmd_pkg::PH_PRESSED;
                            ev.kind = kmd_pkg::EV_PRESSED;
                        end
                        kmd_pkg::PH_PRESSED: begin
                            if (elapsed > hold_us) begin
                                nxt     = kmd_pkg::PH_HELD;
                                ev.kind = kmd_pkg::EV_HELD;
                            end
                        end
                        default: ;
                    endcase
                end else if (ph != kmd_pkg::PH_RELEASED) begin
                    nxt = kmd_pkg::PH_RELEASED;
                    // a key that never got past triggered goes back silently
                    if (ph != kmd_pkg::PH_TRIGGERED) begin
                        ev.kind = kmd_pkg::EV_RELEASED;
                    end
                end
                if (nxt != ph) begin
                    phase_of_key[idx]  = nxt;
                    changed_at_us[idx] = now;
                end
            end
        end
        return ev;
    endfunction

    // checks outgoing words, predicts incoming ones, tracks register writes
    always @(posedge aclk) begin
        key_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("event word with no sample waiting");
            end else begin
                want = pending_events.pop_front();
                if (m_tuser !== want.kind) begin
                    report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                end
                if (m_tdata[kmd_pkg::OUT_ROW_LSB +: kmd_pkg::ROW_W] !== want.row) begin
                    report_mismatch($sformatf("row %0d, want %0d",
                        m_tdata[kmd_pkg::OUT_ROW_LSB +: kmd_pkg::ROW_W], want.row));
                end
                if (m_tdata[kmd_pkg::OUT_COL_LSB +: kmd_pkg::COL_W] !== want.col) begin
                    report_mismatch($sformatf("col %0d, want %0d",
                        m_tdata[kmd_pkg::OUT_COL_LSB +: kmd_pkg::COL_W], want.col));
                end
                kinds_seen[want.kind]++;
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            pending_events.push_back(next_key_event(
                s_tdata[kmd_pkg::IN_ROW_LSB +: kmd_pkg::ROW_W],
                s_tdata[kmd_pkg::IN_COL_LSB +: kmd_pkg::COL_W],
                s_tdata[kmd_pkg::IN_ACTIVE_LSB],
                s_tdata[kmd_pkg::IN_NOW_LSB +: kmd_pkg::TIME_W]));
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                kmd_pkg::REG_DEBOUNCE_TIME: debounce_us = cfg_data;
                kmd_pkg::REG_HOLD_TIME:     hold_us     = cfg_data;
                default: ;
            endcase
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic send_sample(input logic [kmd_pkg::ROW_W-1:0] row,
                               input logic [kmd_pkg::COL_W-1:0] col,
                               input logic active,
                               input logic [kmd_pkg::TIME_W-1:0] now);
        logic [kmd_pkg::IN_DATA_W-1:0] word;
        word = '0;
        word[kmd_pkg::IN_ROW_LSB +: kmd_pkg::ROW_W]  = row;
        word[kmd_pkg::IN_COL_LSB +: kmd_pkg::COL_W]  = col;
        word[kmd_pkg::IN_ACTIVE_LSB]                 = active;
        word[kmd_pkg::IN_NOW_LSB +: kmd_pkg::TIME_W] = now;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        samples_sent++;
    endtask

    task automatic wait_for_all_events();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [kmd_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [kmd_pkg::CFG_DATA_W-1:0] value);
        wait_for_all_events();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // gap between scans, mostly scaled to the current debounce and hold windows, sometimes any value
    function automatic logic [kmd_pkg::TIME_W-1:0] scan_gap();
        case ($urandom_range(9))
            0, 1:    return $urandom_range(debounce_us, 0);
            2, 3, 4, 5: return debounce_us + $urandom_range(debounce_us + 10, 0);
            6, 7, 8: return hold_us + $urandom_range(debounce_us + hold_us + 10, 0);
            default: return $urandom();
        endcase
    endfunction

    task automatic press_sequence(input bit broken);
        logic [kmd_pkg::ROW_W-1:0] row;
        logic [kmd_pkg::COL_W-1:0] col;
        int                        n_on;
        int                        n_off;
        row   = kmd_pkg::ROW_W'($urandom_range(kmd_pkg::ROWS - 1));
        col   = kmd_pkg::COL_W'($urandom_range(kmd_pkg::COLS - 1));
        n_on  = $urandom_range(6, 1);
        n_off = $urandom_range(3, 1);
        for (int i = 0; i < n_on + n_off; i++) begin
            scan_us += scan_gap();
            if (broken) begin
                send_sample(row, col, 1'($urandom_range(1)), scan_us);
            end else begin
                send_sample(row, col, i < n_on, scan_us);
            end
        end
    endtask

    task automatic test_press_hold_release();
        // key at the matrix origin with reset windows of 5000 and 500000
        send_sample(3'd0, 3'd0, 1'b1, 32'd0);       // still inside debounce window
        send_sample(3'd0, 3'd0, 1'b1, 32'd5000);
        send_sample(3'd0, 3'd0, 1'b1, 32'd9999);    // one short of debounce
        send_sample(3'd0, 3'd0, 1'b1, 32'd10000);
        send_sample(3'd0, 3'd0, 1'b1, 32'd510000);  // exactly hold time, not yet held
        send_sample(3'd0, 3'd0, 1'b1, 32'd510001);
        send_sample(3'd0, 3'd0, 1'b1, 32'd600000);
        send_sample(3'd0, 3'd0, 1'b0, 32'd700000);
        // bounce on the far corner: triggered then back with no event reported
        send_sample(3'd7, 3'd7, 1'b1, 32'd6000);
        send_sample(3'd7, 3'd7, 1'b0, 32'd11000);
        send_sample(3'd7, 3'd7, 1'b0, 32'd20000);
    endtask

    task automatic test_timestamp_wrap();
        send_sample(3'd3, 3'd5, 1'b1, 32'hFFFF_F000);
        send_sample(3'd3, 3'd5, 1'b1, 32'h0000_0388);
        send_sample(3'd3, 3'd5, 1'b0, 32'h0000_1710);
    endtask

    task automatic test_register_extremes();
        write_register(kmd_pkg::REG_DEBOUNCE_TIME, '0);
        write_register(kmd_pkg::REG_HOLD_TIME, '0);
        send_sample(3'd2, 3'd6, 1'b1, 32'd100);
        send_sample(3'd2, 3'd6, 1'b1, 32'd100);
        send_sample(3'd2, 3'd6, 1'b1, 32'd100);
        send_sample(3'd2, 3'd6, 1'b1, 32'd101);
        send_sample(3'd2, 3'd6, 1'b0, 32'd101);
        write_register(kmd_pkg::REG_DEBOUNCE_TIME, '1);
        write_register(kmd_pkg::REG_HOLD_TIME, '1);
        send_sample(3'd4, 3'd1, 1'b1, 32'hFFFF_FFFE);
        send_sample(3'd4, 3'd1, 1'b1, 32'hFFFF_FFFF);
        send_sample(3'd4, 3'd1, 1'b1, 32'hFFFF_FFFE);
        send_sample(3'd4, 3'd1, 1'b1, 32'hFFFF_FFFD);  // hold can never be exceeded
        send_sample(3'd4, 3'd1, 1'b0, 32'hFFFF_FFFD);
    endtask

    task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                     input logic [kmd_pkg::TIME_W-1:0] debounce,
                                     input logic [kmd_pkg::TIME_W-1:0] hold);
        int start;
        bit paused;
        int pick;
        write_register(kmd_pkg::REG_DEBOUNCE_TIME, debounce);
        write_register(kmd_pkg::REG_HOLD_TIME, hold);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start  = samples_sent;
        paused = 1'b0;
        while (samples_sent - start < PHASE_ITEMS) begin
            if (!paused && samples_sent - start >= PHASE_ITEMS / 2) begin
                wait_for_all_events();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                press_sequence(1'b0);
            end else if (pick < 85) begin
                press_sequence(1'b1);
            end else begin
                send_sample(kmd_pkg::ROW_W'($urandom_range(kmd_pkg::ROWS - 1)),
                            kmd_pkg::COL_W'($urandom_range(kmd_pkg::COLS - 1)),
                            1'($urandom_range(1)), $urandom());
            end
        end
    endtask

    task automatic test_random_traffic();
        scan_us = 32'hFFF0_0000;
        run_traffic_phase(0, 0, 32'd20, 32'd200);
        run_traffic_phase(69, 0, 32'd0, 32'd30);
        run_traffic_phase(0, 69, 32'd200, 32'd0);
        run_traffic_phase(22, 22, kmd_pkg::DEBOUNCE_RESET, kmd_pkg::HOLD_RESET);
    endtask

    initial begin
        for (int i = 0; i < kmd_pkg::KEY_COUNT; i++) begin
            phase_of_key[i]  = kmd_pkg::PH_RELEASED;
            changed_at_us[i] = '0;
        end
        debounce_us = kmd_pkg::DEBOUNCE_RESET;
        hold_us     = kmd_pkg::HOLD_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_press_hold_release();
        test_timestamp_wrap();
        test_register_extremes();
        test_random_traffic();
        wait_for_all_events();

        $display("sent %0d scan words over four handshake mixes, %0d register writes",
                 samples_sent, reg_writes);
        $display("events seen: %0d quiet, %0d pressed, %0d held, %0d released",
                 kinds_seen[kmd_pkg::EV_NONE], kinds_seen[kmd_pkg::EV_PRESSED],
                 kinds_seen[kmd_pkg::EV_HELD], kinds_seen[kmd_pkg::EV_RELEASED]);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/kmd_pkg.sv
src/kmd_ram.sv
src/kmd_key_store.sv
src/kmd_phase_logic.sv
src/key_matrix_debounce_hold_fsm_top.sv
tb/tb_key_matrix_debounce_hold_fsm_top.sv
